// File: sv/rti_pkg.sv
// rti_pkg: widths, register codes and the queue item type of the ray/triangle unit.
// Used by rti_front, rti_queue, rti_back and ray_triangle_intersect.
// No dependencies.
package rti_pkg;

  // Coordinate width (signed fixed point; the fraction point cancels out)
  localparam int CW   = 16;
  localparam int VW   = 3 * CW;           // packed vertex z:y:x
  localparam int EW   = CW + 1;           // edge and origin offset
  localparam int NPW  = 2 * EW;           // normal partial product
  localparam int NW   = NPW + 1;          // normal component
  localparam int PPW  = EW + CW;          // d x (a - o) partial product
  localparam int PW   = PPW + 1;          // d x (a - o) component
  localparam int DENW = NW + CW + 2;      // n.d
  localparam int NUMW = NW + EW + 2;      // n.(a - o)
  localparam int UW   = EW + PW + 2;      // barycentric numerators
  localparam int CMPW = UW + 3;           // barycentric compare

  // Back end: split of num for the point multiply, divider widths
  localparam int NLO  = NUMW / 2;
  localparam int NHI  = NUMW - NLO;
  localparam int PLW  = CW + NLO + 1;
  localparam int PHW  = CW + NHI;
  localparam int PRW  = CW + NUMW;        // d * num
  localparam int NBW  = PRW + 2;          // 2|d*num| + |den|
  localparam int DW   = DENW + 1;         // 2|den|

  // Queue between front and back
  localparam int QDEPTH = 8;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int CRW    = QAW + 1;

  // Configuration register indexes
  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] REG_VERTEX_A = 2'd0;
  localparam logic [CFG_IW-1:0] REG_VERTEX_B = 2'd1;
  localparam logic [CFG_IW-1:0] REG_VERTEX_C = 2'd2;

  // Cyclic neighbors of an axis for cross products
  localparam int IDX1 [3] = '{1, 2, 0};
  localparam int IDX2 [3] = '{2, 0, 1};

  // One classified ray on its way to the back end
  typedef struct packed {
    logic                  hit;
    logic [2:0][CW-1:0]    o;
    logic [2:0][CW-1:0]    d;
    logic [NUMW-1:0]       num;
    logic [DENW-1:0]       den;
  } rti_item_t;

endpackage

// File: sv/ray_triangle_intersect.sv
// ray_triangle_intersect: top level; vertex registers, credit count, front, queue, back.
// Depends on rti_pkg, rti_front, rti_queue, rti_back.
//
//   channel  ports                                   handshake
//   input    in_origin_*, in_dir_*                   start high, busy low
//   result   out_hit, out_point_*                    out_valid, one cycle
//   config   cfg_index, cfg_wdata                    cfg_we
//
// One ray enters per cycle while busy is low. Its result reaches the out ports through
// five front stages, the queue write and its registered read, three
// multiply/magnitude stages, one divider stage per coordinate bit (16) and the output
// register. Reset (rst_n low at a clock edge) clears the vertex registers and all valid
// bits. busy rises only when the queue credit count runs out; the back end drains the
// queue every cycle, since results cannot be held off.
module ray_triangle_intersect (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [rti_pkg::CW-1:0]     in_origin_x,
  input  logic signed [rti_pkg::CW-1:0]     in_origin_y,
  input  logic signed [rti_pkg::CW-1:0]     in_origin_z,
  input  logic signed [rti_pkg::CW-1:0]     in_dir_x,
  input  logic signed [rti_pkg::CW-1:0]     in_dir_y,
  input  logic signed [rti_pkg::CW-1:0]     in_dir_z,
  input  logic                              cfg_we,
  input  logic [rti_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [rti_pkg::VW-1:0]            cfg_wdata,
  output logic                              out_valid,
  output logic                              out_hit,
  output logic signed [rti_pkg::CW-1:0]     out_point_x,
  output logic signed [rti_pkg::CW-1:0]     out_point_y,
  output logic signed [rti_pkg::CW-1:0]     out_point_z
);
  import rti_pkg::*;

  logic [VW-1:0]       vtx_a_r, vtx_b_r, vtx_c_r;
  logic [CRW-1:0]      cred_r, cred_nxt;
  logic                in_accept;
  logic [2:0][CW-1:0]  in_o, in_d;
  logic                f_push, q_valid;
  rti_item_t           f_item, q_item;
  logic [2:0][CW-1:0]  point;

  assign in_accept = start && !busy;
  assign in_o      = {in_origin_z, in_origin_y, in_origin_x};
  assign in_d      = {in_dir_z, in_dir_y, in_dir_x};

  // vertex registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vtx_a_r <= '0;
      vtx_b_r <= '0;
      vtx_c_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VERTEX_A: vtx_a_r <= cfg_wdata;
        REG_VERTEX_B: vtx_b_r <= cfg_wdata;
        REG_VERTEX_C: vtx_c_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // queue credits: drop one per transfer in, return one per item read out
  assign cred_nxt = cred_r - CRW'(in_accept) + CRW'(q_valid);
  assign busy     = (cred_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) cred_r <= CRW'(QDEPTH);
    else        cred_r <= cred_nxt;
  end

  rti_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_o      (in_o),
    .in_d      (in_d),
    .vtx_a     (vtx_a_r),
    .vtx_b     (vtx_b_r),
    .vtx_c     (vtx_c_r),
    .push      (f_push),
    .item      (f_item)
  );

  rti_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_push),
    .din        (f_item),
    .dout_valid (q_valid),
    .dout       (q_item)
  );

  rti_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_valid),
    .in_item   (q_item),
    .out_valid (out_valid),
    .out_hit   (out_hit),
    .out_point (point)
  );

  assign out_point_x = point[0];
  assign out_point_y = point[1];
  assign out_point_z = point[2];

endmodule

// File: sv/rti_front.sv
// rti_front: five-stage front end; forms normal, n.d, n.(a-o) and the hit decision.
// Depends on rti_pkg.
module rti_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_accept,
  input  logic [2:0][rti_pkg::CW-1:0]        in_o,
  input  logic [2:0][rti_pkg::CW-1:0]        in_d,
  input  logic [rti_pkg::VW-1:0]             vtx_a,
  input  logic [rti_pkg::VW-1:0]             vtx_b,
  input  logic [rti_pkg::VW-1:0]             vtx_c,
  output logic                               push,
  output rti_pkg::rti_item_t                 item
);
  import rti_pkg::*;

  // stage 0: edges and origin offset
  logic                    v0_r;
  logic signed [EW-1:0]    e1_0_r [3];
  logic signed [EW-1:0]    e0_0_r [3];
  logic signed [EW-1:0]    ao_0_r [3];
  logic [2:0][CW-1:0]      o0_r, d0_r;

  // stage 1: cross product partials
  logic                    v1_r;
  logic signed [NPW-1:0]   npa_r [3];
  logic signed [NPW-1:0]   npb_r [3];
  logic signed [PPW-1:0]   ppa_r [3];
  logic signed [PPW-1:0]   ppb_r [3];
  logic signed [EW-1:0]    e1_1_r [3];
  logic signed [EW-1:0]    e0_1_r [3];
  logic signed [EW-1:0]    ao_1_r [3];
  logic [2:0][CW-1:0]      o1_r, d1_r;

  // stage 2: normal and d x (a - o)
  logic                    v2_r;
  logic signed [NW-1:0]    n_r [3];
  logic signed [PW-1:0]    p_r [3];
  logic signed [EW-1:0]    e1_2_r [3];
  logic signed [EW-1:0]    e0_2_r [3];
  logic signed [EW-1:0]    ao_2_r [3];
  logic [2:0][CW-1:0]      o2_r, d2_r;

  // stage 3: dot product terms
  logic                    v3_r;
  logic signed [DENW-1:0]  denp_r [3];
  logic signed [NUMW-1:0]  nump_r [3];
  logic signed [UW-1:0]    up_r [3];
  logic signed [UW-1:0]    vp_r [3];
  logic [2:0][CW-1:0]      o3_r, d3_r;

  // stage 4: dot products
  logic                    v4_r;
  logic signed [DENW-1:0]  den_r;
  logic signed [NUMW-1:0]  num_r;
  logic signed [UW-1:0]    u_r;
  logic signed [UW-1:0]    vn_r;
  logic [2:0][CW-1:0]      o4_r, d4_r;

  // classification
  logic                    den_neg, den_zero, hit;
  logic signed [UW:0]      us, vs;
  logic signed [CMPW-1:0]  uv_sum, den_abs;

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v0_r <= in_accept;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      e1_0_r[k] <= EW'($signed(vtx_b[k*CW +: CW])) - EW'($signed(vtx_a[k*CW +: CW]));
      e0_0_r[k] <= EW'($signed(vtx_c[k*CW +: CW])) - EW'($signed(vtx_a[k*CW +: CW]));
      ao_0_r[k] <= EW'($signed(vtx_a[k*CW +: CW])) - EW'($signed(in_o[k]));

      npa_r[k] <= NPW'(e1_0_r[IDX1[k]]) * NPW'(e0_0_r[IDX2[k]]);
      npb_r[k] <= NPW'(e1_0_r[IDX2[k]]) * NPW'(e0_0_r[IDX1[k]]);
      ppa_r[k] <= PPW'($signed(d0_r[IDX1[k]])) * PPW'(ao_0_r[IDX2[k]]);
      ppb_r[k] <= PPW'($signed(d0_r[IDX2[k]])) * PPW'(ao_0_r[IDX1[k]]);
      e1_1_r[k] <= e1_0_r[k];
      e0_1_r[k] <= e0_0_r[k];
      ao_1_r[k] <= ao_0_r[k];

      n_r[k] <= NW'(npa_r[k]) - NW'(npb_r[k]);
      p_r[k] <= PW'(ppa_r[k]) - PW'(ppb_r[k]);
      e1_2_r[k] <= e1_1_r[k];
      e0_2_r[k] <= e0_1_r[k];
      ao_2_r[k] <= ao_1_r[k];

      denp_r[k] <= DENW'(n_r[k]) * DENW'($signed(d2_r[k]));
      nump_r[k] <= NUMW'(n_r[k]) * NUMW'(ao_2_r[k]);
      up_r[k]   <= UW'(e1_2_r[k]) * UW'(p_r[k]);
      vp_r[k]   <= UW'(e0_2_r[k]) * UW'(p_r[k]);
    end
    o0_r <= in_o;
    d0_r <= in_d;
    o1_r <= o0_r;
    d1_r <= d0_r;
    o2_r <= o1_r;
    d2_r <= d1_r;
    o3_r <= o2_r;
    d3_r <= d2_r;

    den_r <= denp_r[0] + denp_r[1] + denp_r[2];
    num_r <= nump_r[0] + nump_r[1] + nump_r[2];
    u_r   <= up_r[0] + up_r[1] + up_r[2];
    vn_r  <= vp_r[0] + vp_r[1] + vp_r[2];
    o4_r  <= o3_r;
    d4_r  <= d3_r;
  end

  // strict barycentric test, signs normalized to a positive n.d
  always_comb begin
    den_neg  = den_r[DENW-1];
    den_zero = (den_r == '0);
    us       = den_neg ? -(UW+1)'(u_r) : (UW+1)'(u_r);
    vs       = den_neg ? (UW+1)'(vn_r) : -(UW+1)'(vn_r);
    uv_sum   = CMPW'(us) + CMPW'(vs);
    den_abs  = den_neg ? -CMPW'(den_r) : CMPW'(den_r);
    hit      = !den_zero && !us[UW] && (us != '0) && !vs[UW] && (vs != '0)
               && (uv_sum < den_abs);
  end

  // transfer into the queue
  assign push      = v4_r;
  assign item.hit  = hit;
  assign item.o    = o4_r;
  assign item.d    = d4_r;
  assign item.num  = num_r;
  assign item.den  = den_r;

endmodule

// File: sv/rti_queue.sv
// rti_queue: short FIFO between front and back end; drains one item per cycle.
// Depends on rti_pkg.
module rti_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rti_pkg::rti_item_t  din,
  output logic                dout_valid,
  output rti_pkg::rti_item_t  dout
);
  import rti_pkg::*;

  rti_item_t        mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CRW-1:0]   cnt_r, cnt_nxt;
  logic             pop;
  logic             valid_r;
  rti_item_t        dout_r;

  assign pop     = (cnt_r != '0);
  assign cnt_nxt = cnt_r + CRW'(push) - CRW'(pop);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      valid_r  <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r   <= cnt_nxt;
      valid_r <= pop;
    end
  end

  // storage with registered read
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= din;
    if (pop)  dout_r <= mem[rd_ptr_r];
  end

  assign dout_valid = valid_r;
  assign dout       = dout_r;

endmodule

// File: sv/rti_back.sv
// rti_back: back end; forms o + round(d*num/den) per axis with a pipelined divider.
// Depends on rti_pkg.
module rti_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  rti_pkg::rti_item_t           in_item,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic [2:0][rti_pkg::CW-1:0]  out_point
);
  import rti_pkg::*;

  // B0: partial products of d * num
  logic                    b0_v_r, b0_hit_r;
  logic signed [PLW-1:0]   pl_r [3];
  logic signed [PHW-1:0]   ph_r [3];
  logic [2:0][CW-1:0]      b0_o_r;
  logic signed [DENW-1:0]  b0_den_r;

  // B1: magnitudes and quotient sign
  logic                    b1_v_r, b1_hit_r;
  logic [PRW-1:0]          absp_r [3];
  logic [2:0]              b1_neg_r;
  logic [2:0][CW-1:0]      b1_o_r;
  logic [DENW-1:0]         absden_r;
  logic signed [PRW-1:0]   prod [3];
  logic signed [DENW-1:0]  absden_c;

  // divider stages: index 0 is loaded from B1
  logic                    dv_r   [CW+1];
  logic                    dh_r   [CW+1];
  logic [2:0][CW-1:0]      do_r   [CW+1];
  logic [2:0]              dneg_r [CW+1];
  logic [2:0]              dovf_r [CW+1];
  logic [DW-1:0]           dd_r   [CW+1];
  logic [NBW-1:0]          drem_r [CW+1][3];
  logic [CW-1:0]           dquo_r [CW+1][3];

  // final rounding, saturation
  logic [CW:0]             qmag [3];
  logic signed [CW+1:0]    qsig [3];
  logic signed [CW+2:0]    psum [3];
  logic [2:0][CW-1:0]      psat;
  logic                    out_valid_r, out_hit_r;
  logic [2:0][CW-1:0]      out_point_r;

  localparam logic signed [CW+2:0] PMAX = (CW+3)'((1 << (CW-1)) - 1);
  localparam logic signed [CW+2:0] PMIN = -(CW+3)'(1 << (CW-1));

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r      <= 1'b0;
      b1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int s = 0; s <= CW; s++) dv_r[s] <= 1'b0;
    end else begin
      b0_v_r   <= in_valid;
      b1_v_r   <= b0_v_r;
      dv_r[0]  <= b1_v_r;
      for (int s = 0; s < CW; s++) dv_r[s+1] <= dv_r[s];
      out_valid_r <= dv_r[CW];
    end
  end

  // B1 combinational: product assembly and magnitude of den
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = (PRW'(ph_r[k]) <<< NLO) + PRW'(pl_r[k]);
    end
    absden_c = b0_den_r[DENW-1] ? -b0_den_r : b0_den_r;
  end

  // front of the back end: multiply, magnitudes
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pl_r[k] <= PLW'($signed(in_item.d[k])) * PLW'($signed({1'b0, in_item.num[NLO-1:0]}));
      ph_r[k] <= PHW'($signed(in_item.d[k])) * PHW'($signed(in_item.num[NUMW-1:NLO]));

      absp_r[k]   <= prod[k][PRW-1] ? PRW'(-prod[k]) : PRW'(prod[k]);
      b1_neg_r[k] <= prod[k][PRW-1] ^ b0_den_r[DENW-1];
    end
    b0_hit_r <= in_item.hit;
    b0_o_r   <= in_item.o;
    b0_den_r <= in_item.den;

    b1_hit_r <= b0_hit_r;
    b1_o_r   <= b0_o_r;
    absden_r <= absden_c;
  end

  // load dividend and divisor, then restoring division, one quotient bit per stage
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      drem_r[0][k] <= (NBW'(absp_r[k]) << 1) + NBW'(absden_r);
      dovf_r[0][k] <= ((NBW'(absp_r[k]) << 1) + NBW'(absden_r))
                      >= (NBW'({absden_r, 1'b0}) << CW);
      dquo_r[0][k] <= '0;
    end
    dh_r[0]   <= b1_hit_r;
    do_r[0]   <= b1_o_r;
    dneg_r[0] <= b1_neg_r;
    dd_r[0]   <= {absden_r, 1'b0};

    for (int s = 0; s < CW; s++) begin
      for (int k = 0; k < 3; k++) begin
        if (drem_r[s][k] >= (NBW'(dd_r[s]) << (CW - 1 - s))) begin
          drem_r[s+1][k] <= drem_r[s][k] - (NBW'(dd_r[s]) << (CW - 1 - s));
          dquo_r[s+1][k] <= {dquo_r[s][k][CW-2:0], 1'b1};
        end else begin
          drem_r[s+1][k] <= drem_r[s][k];
          dquo_r[s+1][k] <= {dquo_r[s][k][CW-2:0], 1'b0};
        end
      end
      dh_r[s+1]   <= dh_r[s];
      do_r[s+1]   <= do_r[s];
      dneg_r[s+1] <= dneg_r[s];
      dovf_r[s+1] <= dovf_r[s];
      dd_r[s+1]   <= dd_r[s];
    end
  end

  // apply sign, add origin, saturate
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qmag[k] = dovf_r[CW][k] ? (CW+1)'(1 << CW) : {1'b0, dquo_r[CW][k]};
      qsig[k] = dneg_r[CW][k] ? -(CW+2)'(qmag[k]) : (CW+2)'(qmag[k]);
      psum[k] = (CW+3)'($signed(do_r[CW][k])) + (CW+3)'(qsig[k]);
      if (psum[k] > PMAX)      psat[k] = PMAX[CW-1:0];
      else if (psum[k] < PMIN) psat[k] = PMIN[CW-1:0];
      else                     psat[k] = psum[k][CW-1:0];
    end
  end

  // result register; zero point on a miss
  always_ff @(posedge clk) begin
    out_hit_r   <= dh_r[CW];
    out_point_r <= dh_r[CW] ? psat : '0;
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_point = out_point_r;

endmodule
